/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pidc_pkg.sv */
package pidc_pkg;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_KP_GAIN     = 3'd0;
  localparam reg_idx_t REG_KI_GAIN     = 3'd1;
  localparam reg_idx_t REG_KD_GAIN     = 3'd2;
  localparam reg_idx_t REG_INTEG_LIMIT = 3'd3;
  localparam reg_idx_t REG_DERIV_LIMIT = 3'd4;
  localparam reg_idx_t REG_OUT_LIMIT   = 3'd5;
  localparam reg_idx_t REG_ERR_LIMIT   = 3'd6;

  localparam logic [14:0] LIMIT_RESET = 15'h7fff;

  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [15:0] kp_gain;
    logic signed [15:0] ki_gain;
    logic signed [15:0] kd_gain;
    logic [14:0]        integ_limit;
    logic [14:0]        deriv_limit;
    logic [14:0]        out_limit;
    logic [14:0]        err_limit;
  } pidc_cfg_t;

endpackage

/* design/pidc_cfg_regs.sv */
module pidc_cfg_regs
  import pidc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output pidc_cfg_t          cfg
);

  pidc_cfg_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain     <= '0;
      cfg_r.ki_gain     <= '0;
      cfg_r.kd_gain     <= '0;
      cfg_r.integ_limit <= LIMIT_RESET;
      cfg_r.deriv_limit <= LIMIT_RESET;
      cfg_r.out_limit   <= LIMIT_RESET;
      cfg_r.err_limit   <= LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_KP_GAIN:     cfg_r.kp_gain     <= $signed(pwdata[15:0]);
        REG_KI_GAIN:     cfg_r.ki_gain     <= $signed(pwdata[15:0]);
        REG_KD_GAIN:     cfg_r.kd_gain     <= $signed(pwdata[15:0]);
        REG_INTEG_LIMIT: cfg_r.integ_limit <= pwdata[14:0];
        REG_DERIV_LIMIT: cfg_r.deriv_limit <= pwdata[14:0];
        REG_OUT_LIMIT:   cfg_r.out_limit   <= pwdata[14:0];
        REG_ERR_LIMIT:   cfg_r.err_limit   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP_GAIN:     prdata = {16'd0, cfg_r.kp_gain};
      REG_KI_GAIN:     prdata = {16'd0, cfg_r.ki_gain};
      REG_KD_GAIN:     prdata = {16'd0, cfg_r.kd_gain};
      REG_INTEG_LIMIT: prdata = {17'd0, cfg_r.integ_limit};
      REG_DERIV_LIMIT: prdata = {17'd0, cfg_r.deriv_limit};
      REG_OUT_LIMIT:   prdata = {17'd0, cfg_r.out_limit};
      REG_ERR_LIMIT:   prdata = {17'd0, cfg_r.err_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

/* design/pidc_core.sv */
module pidc_core
  import pidc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pidc_cfg_t          cfg,
  input  logic               advance,
  input  logic               action,
  input  logic signed [15:0] feedback,
  input  logic signed [15:0] setpoint,
  output logic signed [15:0] drive_nxt
);

  logic signed [15:0] integ_r, integ_nxt;
  logic signed [15:0] prev_err_r;

  logic signed [16:0] diff;
  logic signed [15:0] err;
  logic signed [31:0] kp_prod;
  logic signed [31:0] ki_prod;
  logic signed [16:0] err_delta;
  logic signed [32:0] kd_prod;
  logic signed [23:0] p_term;
  logic signed [23:0] ki_term;
  logic signed [24:0] d_raw;
  logic signed [15:0] d_term;
  logic signed [25:0] integ_sum;
  logic signed [25:0] total;
  logic signed [15:0] drive_step;

  // Symmetric clamp; every caller's value fits in 26 bits.
  function automatic logic signed [15:0] clamp_sym(input logic signed [25:0] v,
                                                   input logic [14:0] lim);
    logic signed [25:0] pos;
    logic signed [25:0] neg;
    pos = $signed({11'd0, lim});
    neg = -pos;
    if (v > pos) begin
      clamp_sym = pos[15:0];
    end else if (v < neg) begin
      clamp_sym = neg[15:0];
    end else begin
      clamp_sym = v[15:0];
    end
  endfunction

  always_comb begin
    diff       = 17'(setpoint) - 17'(feedback);
    err        = clamp_sym(26'(diff), cfg.err_limit);
    kp_prod    = 32'(cfg.kp_gain) * 32'(err);
    ki_prod    = 32'(cfg.ki_gain) * 32'(err);
    err_delta  = 17'(err) - 17'(prev_err_r);
    kd_prod    = 33'(cfg.kd_gain) * 33'(err_delta);
    // drop the Q8.8 fraction, rounding toward minus infinity
    p_term     = $signed(kp_prod[31:8]);
    ki_term    = $signed(ki_prod[31:8]);
    d_raw      = $signed(kd_prod[32:8]);
    integ_sum  = 26'(integ_r) + 26'(ki_term);
    integ_nxt  = clamp_sym(integ_sum, cfg.integ_limit);
    d_term     = clamp_sym(26'(d_raw), cfg.deriv_limit);
    total      = 26'(p_term) + 26'(integ_nxt) + 26'(d_term);
    drive_step = clamp_sym(total, cfg.out_limit);
    drive_nxt  = (action == ACT_CLEAR) ? 16'sd0 : drive_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else if (advance) begin
      if (action == ACT_CLEAR) begin
        integ_r    <= '0;
        prev_err_r <= '0;
      end else begin
        integ_r    <= integ_nxt;
        prev_err_r <= err;
      end
    end
  end

endmodule

/* design/pid_controller_clamped.sv */
// Channel   | Ports                                   | Moves
// ----------+-----------------------------------------+-------------------------
// input     | in_valid/in_ready, in_action,            | one step or clear word
//           | in_feedback, in_setpoint                 |
// result    | out_valid/out_ready, out_drive           | one drive word per input
// config    | psel/penable/pwrite/paddr/pwdata/prdata  | gain and limit registers
//
// One word per cycle sustained while out_ready is high; an accepted word waits
// in the input register, and the single PID pass lands it in the result
// register, raising out_valid, once the result side is free. The integrator and
// previous error update in that pass, so consecutive words chain without gaps.
// Synchronous reset clears the pipeline and the state and resets the registers.
// A stall holds the stored words; in_ready stays high while out_ready is high.
module pid_controller_clamped
  import pidc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [15:0] in_feedback,
  input  logic signed [15:0] in_setpoint,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  pidc_cfg_t cfg;

  logic               s1_valid_r;
  logic               s1_action_r;
  logic signed [15:0] s1_feedback_r;
  logic signed [15:0] s1_setpoint_r;
  logic               out_valid_r;
  logic signed [15:0] out_drive_r;
  logic signed [15:0] drive_nxt;
  logic               advance;
  logic               in_take;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  pidc_cfg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  pidc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .advance  (advance),
    .action   (s1_action_r),
    .feedback (s1_feedback_r),
    .setpoint (s1_setpoint_r),
    .drive_nxt(drive_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold unless a new word lands
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r   <= in_action;
      s1_feedback_r <= in_feedback;
      s1_setpoint_r <= in_setpoint;
    end
    if (advance) begin
      out_drive_r <= drive_nxt;
    end
  end

endmodule

/* design/pidc_checker.sv */
`include "assert_macros.svh"

module pidc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_drive
);

  // a stalled result holds its word
  `ASSERT_CHK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_drive), "result word changed while stalled")

  // every clamp is symmetric, so the most negative code never appears
  `ASSERT_CHK(a_drive_range, out_valid |-> out_drive != 16'h8000, "drive outside symmetric range")

  // a draining output never blocks the input side
  `ASSERT_CHK(a_ready_pass, out_ready |-> in_ready, "input stalled while result side drains")

  `ASSERT_ANY(a_reset_empty, !rst_n |=> !out_valid, "result valid straight after reset")

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_drive(out_drive)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import pidc_pkg::*;

  localparam int       CYCLE_LIMIT = 300000;
  localparam int       SETTLE      = 4;
  localparam reg_idx_t REG_UNUSED  = 3'd7;

  typedef struct {
    logic               act;
    logic signed [15:0] fb;
    logic signed [15:0] sp;
  } ctl_word_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               in_action   = ACT_STEP;
  logic signed [15:0] in_feedback = '0;
  logic signed [15:0] in_setpoint = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic signed [15:0] out_drive;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // register copy and controller state as the block should hold them
  logic signed [15:0] kp_cfg = '0;
  logic signed [15:0] ki_cfg = '0;
  logic signed [15:0] kd_cfg = '0;
  logic [14:0]        integ_lim = LIMIT_RESET;
  logic [14:0]        deriv_lim = LIMIT_RESET;
  logic [14:0]        out_lim   = LIMIT_RESET;
  logic [14:0]        err_lim   = LIMIT_RESET;
  longint             integ_acc = 0;
  longint             err_prev  = 0;

  ctl_word_t          pending_words[$];
  logic signed [15:0] drive_expected[$];
  ctl_word_t          next_word;
  int                 gap_left    = 0;
  int                 stall_left  = 0;
  bit                 idle_on     = 1'b1;
  int                 err_count   = 0;
  int                 cycle_count = 0;

  pid_controller_clamped DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_feedback(in_feedback),
    .in_setpoint(in_setpoint),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_drive  (out_drive),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic longint sym_clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [15:0] predict_drive(logic act, logic signed [15:0] fb,
                                                       logic signed [15:0] sp);
    longint err;
    longint p_term;
    longint d_term;
    longint sum;
    if (act == ACT_CLEAR) begin
      integ_acc = 0;
      err_prev  = 0;
      return '0;
    end
    // error taken at full width, so opposite extremes do not wrap
    err    = sym_clamp(longint'(sp) - longint'(fb), longint'(err_lim));
    p_term = (longint'(kp_cfg) * err) >>> 8;
    integ_acc = sym_clamp(integ_acc + ((longint'(ki_cfg) * err) >>> 8), longint'(integ_lim));
    d_term = sym_clamp((longint'(kd_cfg) * (err - err_prev)) >>> 8, longint'(deriv_lim));
    sum    = sym_clamp(p_term + integ_acc + d_term, longint'(out_lim));
    err_prev = err;
    return 16'(sum);
  endfunction

  // driver: one word per free slot, with short gaps when idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        drive_expected.push_back(predict_drive(in_action, in_feedback, in_setpoint));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_valid    <= 1'b1;
          in_action   <= next_word.act;
          in_feedback <= next_word.fb;
          in_setpoint <= next_word.sp;
          if (idle_on && $urandom_range(0, 3) == 0)
            gap_left <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each drive word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          $error("drive word %0d arrived with nothing expected", out_drive);
          err_count <= err_count + 1;
        end else if (out_drive !== drive_expected[0]) begin
          $error("drive: expected %0d, actual %0d", drive_expected[0], out_drive);
          err_count <= err_count + 1;
          void'(drive_expected.pop_front());
        end else begin
          void'(drive_expected.pop_front());
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bits above each register's width are dropped
    case (idx)
      REG_KP_GAIN:     kp_cfg    = val[15:0];
      REG_KI_GAIN:     ki_cfg    = val[15:0];
      REG_KD_GAIN:     kd_cfg    = val[15:0];
      REG_INTEG_LIMIT: integ_lim = val[14:0];
      REG_DERIV_LIMIT: deriv_lim = val[14:0];
      REG_OUT_LIMIT:   out_lim   = val[14:0];
      REG_ERR_LIMIT:   err_lim   = val[14:0];
      default: ;
    endcase
  endtask

  task automatic queue_word(logic act, logic signed [15:0] fb, logic signed [15:0] sp);
    ctl_word_t w;
    w.act = act;
    w.fb  = fb;
    w.sp  = sp;
    pending_words.push_back(w);
  endtask

  // hold until every word is through, then let the pipeline settle
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || drive_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    logic [15:0] g;
    case ($urandom_range(0, 5))
      0: g = 16'h8000;
      1: g = 16'h7fff;
      2: g = 16'($urandom_range(0, 1024)) - 16'd512;
      default: g = 16'($urandom);
    endcase
    return {16'($urandom), g};
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [14:0] l;
    case ($urandom_range(0, 5))
      0: l = '0;
      1: l = LIMIT_RESET;
      2: l = 15'($urandom_range(1, 300));
      default: l = 15'($urandom);
    endcase
    return {17'($urandom), l};
  endfunction

  task automatic queue_random(int n);
    ctl_word_t w;
    repeat (n) begin
      w.act = ($urandom_range(0, 19) == 0) ? ACT_CLEAR : ACT_STEP;
      w.fb  = 16'($urandom);
      case ($urandom_range(0, 3))
        0: w.sp = 16'($urandom);
        1: begin
          w.fb = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
          w.sp = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        end
        // small errors let the integrator build up without slamming its clamp
        default: w.sp = w.fb + 16'($urandom_range(0, 400)) - 16'd200;
      endcase
      pending_words.push_back(w);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero gains give a zero drive
    queue_word(ACT_STEP, 16'sh8000, 16'sh7fff);
    queue_word(ACT_STEP, 16'sh0123, 16'sh0000);
    drain();

    reg_write(REG_KP_GAIN,     32'hdead_0100);
    reg_write(REG_KI_GAIN,     32'h0000_0080);
    reg_write(REG_KD_GAIN,     32'hffff_0200);
    reg_write(REG_INTEG_LIMIT, 32'hffff_83e8);
    reg_write(REG_DERIV_LIMIT, 32'h0001_7fff);
    reg_write(REG_OUT_LIMIT,   32'h0000_7fff);
    reg_write(REG_ERR_LIMIT,   32'h8000_7fff);
    reg_write(REG_UNUSED,      32'h0000_0001);
    queue_word(ACT_STEP,  16'sh0000, 16'sh0000);
    queue_word(ACT_STEP,  16'sh8000, 16'sh7fff);
    queue_word(ACT_STEP,  16'sh8000, 16'sh7fff);
    queue_word(ACT_STEP,  16'sh7fff, 16'sh8000);
    queue_word(ACT_STEP,  16'sh7fff, 16'sh8000);
    queue_word(ACT_CLEAR, 16'sh1234, 16'sh8765);
    queue_word(ACT_STEP,  16'sh0001, 16'sh0000);
    queue_word(ACT_STEP,  16'sh0000, 16'sh0001);
    queue_word(ACT_STEP,  16'sh0064, 16'sh0000);
    queue_word(ACT_STEP,  16'sh0000, 16'sh0064);
    queue_word(ACT_CLEAR, 16'sh7fff, 16'sh8000);
    queue_word(ACT_STEP,  16'shffff, 16'sh0000);
    drain();

    // zero limits force every term to zero
    reg_write(REG_KP_GAIN,     32'h0000_7fff);
    reg_write(REG_KI_GAIN,     32'h0000_8000);
    reg_write(REG_KD_GAIN,     32'h0000_7fff);
    reg_write(REG_INTEG_LIMIT, 32'h0000_0000);
    reg_write(REG_DERIV_LIMIT, 32'hffff_8000);
    reg_write(REG_OUT_LIMIT,   32'h0000_0000);
    reg_write(REG_ERR_LIMIT,   32'h0000_8000);
    queue_random(10);
    drain();

    // largest gains, widest limits
    reg_write(REG_INTEG_LIMIT, 32'h0000_7fff);
    reg_write(REG_DERIV_LIMIT, 32'h0000_7fff);
    reg_write(REG_OUT_LIMIT,   32'h0000_7fff);
    reg_write(REG_ERR_LIMIT,   32'h0000_7fff);
    queue_word(ACT_STEP, 16'sh8000, 16'sh7fff);
    queue_word(ACT_STEP, 16'sh7fff, 16'sh8000);
    queue_random(8);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      reg_write(REG_KP_GAIN,     pick_gain());
      reg_write(REG_KI_GAIN,     pick_gain());
      reg_write(REG_KD_GAIN,     pick_gain());
      reg_write(REG_INTEG_LIMIT, pick_limit());
      reg_write(REG_DERIV_LIMIT, pick_limit());
      reg_write(REG_OUT_LIMIT,   pick_limit());
      reg_write(REG_ERR_LIMIT,   pick_limit());
      queue_random(110);
      drain();
    end

    if (err_count == 0 && drive_expected.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
